// ===== rtl/pmid_pkg.sv =====
// Shared types, widths and constants for the periodic minimum-image distance block.
// Used by every module under rtl; depends on nothing else.
`timescale 1ns / 1ps

package pmid_pkg;

  // Spatial dimension: 1 or 2
  localparam int DIM = 2;
  localparam bit USE_Y = (DIM > 1);

  // Fixed-point layout
  localparam int COORD_W = 32;              // Q16.16 coordinates and box entries
  localparam int Q_POS   = 16;              // fraction bits of a coordinate
  localparam int Q_INV   = 28;              // fraction bits of inverse entries and fractions
  localparam int DIFF_W  = COORD_W + 1;     // exact coordinate difference
  localparam int PROD1_W = COORD_W + DIFF_W;  // inverse entry times difference
  localparam int ACC1_W  = PROD1_W + 1;     // sum over two columns
  localparam int FRAC_W  = ACC1_W - Q_POS;  // box fraction, Q.28
  localparam int LO_W    = 25;              // low slice of a fraction, unsigned
  localparam int HI_W    = FRAC_W - LO_W;   // high slice of a fraction, signed
  localparam int PPH_W   = COORD_W + HI_W;  // box entry times high slice
  localparam int PPL_W   = COORD_W + LO_W + 1;  // box entry times low slice
  localparam int TERM_W  = COORD_W + FRAC_W;  // full box entry times fraction
  localparam int ACC2_W  = TERM_W + 1;      // sum over two fractions
  localparam int DISP_W  = ACC2_W - Q_INV;  // unsaturated displacement, Q39.16
  localparam int DIST_W  = 2 * COORD_W;     // squared length, Q32.32

  localparam logic signed [FRAC_W-1:0] HALF_Q28 = FRAC_W'(longint'(1) <<< (Q_INV - 1));
  localparam logic signed [FRAC_W-1:0] ONE_Q28  = FRAC_W'(longint'(1) <<< Q_INV);
  localparam logic signed [FRAC_W-1:0] NEG_HALF_Q28 = -HALF_Q28;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_INV_ROW_ZERO = 3'd0,
    REG_INV_ROW_ONE  = 3'd1,
    REG_FWD_ROW_ZERO = 3'd2,
    REG_FWD_ROW_ONE  = 3'd3,
    REG_WRAP_AXES    = 3'd4
  } reg_idx_t;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;

  // Input word: two points
  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
  } in_word_t;

  // Result word: displacement and squared length
  typedef struct packed {
    logic signed [COORD_W-1:0] disp_x;
    logic signed [COORD_W-1:0] disp_y;
    logic        [DIST_W-1:0]  dist_sq;
  } out_word_t;

  // Current register contents, split into matrix entries
  typedef struct packed {
    logic signed [COORD_W-1:0] inv00;
    logic signed [COORD_W-1:0] inv01;
    logic signed [COORD_W-1:0] inv10;
    logic signed [COORD_W-1:0] inv11;
    logic signed [COORD_W-1:0] fwd00;
    logic signed [COORD_W-1:0] fwd01;
    logic signed [COORD_W-1:0] fwd10;
    logic signed [COORD_W-1:0] fwd11;
    logic        [1:0]         wrap;
  } cfg_t;

  // Wrapped box fractions between the two halves of the pipeline
  typedef struct packed {
    logic signed [FRAC_W-1:0] frac_x;
    logic signed [FRAC_W-1:0] frac_y;
  } frac_t;

endpackage

// ===== rtl/pmid_regs.sv =====
// Configuration register file: inverse and forward box matrices and wrap bits.
// Depends on pmid_pkg.
`timescale 1ns / 1ps

module pmid_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pmid_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pmid_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output pmid_pkg::cfg_t                      cfg
);

  logic [pmid_pkg::CFG_DATA_W-1:0] inv_row_zero_r, inv_row_one_r;
  logic [pmid_pkg::CFG_DATA_W-1:0] fwd_row_zero_r, fwd_row_one_r;
  logic [1:0]                      wrap_axes_r;

  // Write one register; unknown indexes drop the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_row_zero_r <= 64'h0000_0000_1000_0000;
      inv_row_one_r  <= 64'h1000_0000_0000_0000;
      fwd_row_zero_r <= 64'h0000_0000_0001_0000;
      fwd_row_one_r  <= 64'h0001_0000_0000_0000;
      wrap_axes_r    <= 2'b00;
    end else if (cfg_we) begin
      case (pmid_pkg::reg_idx_t'(cfg_addr))
        pmid_pkg::REG_INV_ROW_ZERO: inv_row_zero_r <= cfg_wdata;
        pmid_pkg::REG_INV_ROW_ONE:  inv_row_one_r  <= cfg_wdata;
        pmid_pkg::REG_FWD_ROW_ZERO: fwd_row_zero_r <= cfg_wdata;
        pmid_pkg::REG_FWD_ROW_ONE:  fwd_row_one_r  <= cfg_wdata;
        pmid_pkg::REG_WRAP_AXES:    wrap_axes_r    <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Column zero sits in the low half of each row
  assign cfg.inv00 = inv_row_zero_r[31:0];
  assign cfg.inv01 = inv_row_zero_r[63:32];
  assign cfg.inv10 = inv_row_one_r[31:0];
  assign cfg.inv11 = inv_row_one_r[63:32];
  assign cfg.fwd00 = fwd_row_zero_r[31:0];
  assign cfg.fwd01 = fwd_row_zero_r[63:32];
  assign cfg.fwd10 = fwd_row_one_r[31:0];
  assign cfg.fwd11 = fwd_row_one_r[63:32];
  assign cfg.wrap  = wrap_axes_r;

endmodule

// ===== rtl/pmid_frac.sv =====
// Front half of the pipeline: difference, inverse matrix products, minimum-image wrap.
// Three register stages; depends on pmid_pkg.
`timescale 1ns / 1ps

module pmid_frac (
  input  logic                clk,
  input  logic                rst_n,
  input  pmid_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  pmid_pkg::in_word_t  in_word,
  output logic                frac_valid,
  input  logic                frac_stall,
  output pmid_pkg::frac_t     frac_word
);

  localparam int NST = 3;

  logic [NST-1:0] v_r, v_nxt, rdy;

  logic signed [pmid_pkg::DIFF_W-1:0]  dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [pmid_pkg::PROD1_W-1:0] p00_r, p01_r, p10_r, p11_r;
  logic signed [pmid_pkg::PROD1_W-1:0] p00_nxt, p01_nxt, p10_nxt, p11_nxt;
  logic signed [pmid_pkg::ACC1_W-1:0]  acc0, acc1;
  pmid_pkg::frac_t                     frac_r, frac_nxt;

  // Move a fraction of half a box or more back by one box
  function automatic logic signed [pmid_pkg::FRAC_W-1:0] wrap_frac(
    input logic signed [pmid_pkg::FRAC_W-1:0] s,
    input logic                               en
  );
    logic signed [pmid_pkg::FRAC_W-1:0] r;
    r = s;
    if (en) begin
      if (s >= pmid_pkg::HALF_Q28) begin
        r = s - pmid_pkg::ONE_Q28;
      end else if (s <= pmid_pkg::NEG_HALF_Q28) begin
        r = s + pmid_pkg::ONE_Q28;
      end
    end
    return r;
  endfunction

  // Stage ready chain: a stage takes a word when empty or when it drains
  always_comb begin
    rdy[NST-1] = !v_r[NST-1] || !frac_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    for (int k = 0; k < NST; k++) begin
      if (!rdy[k]) begin
        v_nxt[k] = v_r[k];
      end else if (k == 0) begin
        v_nxt[k] = in_valid;
      end else begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Stage 1: exact difference, second minus first
  always_comb begin
    dx_nxt = pmid_pkg::DIFF_W'(in_word.second_x) - pmid_pkg::DIFF_W'(in_word.first_x);
    if (pmid_pkg::USE_Y) begin
      dy_nxt = pmid_pkg::DIFF_W'(in_word.second_y) - pmid_pkg::DIFF_W'(in_word.first_y);
    end else begin
      dy_nxt = '0;
    end
  end

  // Stage 2: inverse matrix entry times difference
  always_comb begin
    p00_nxt = pmid_pkg::PROD1_W'(cfg.inv00) * pmid_pkg::PROD1_W'(dx_r);
    p01_nxt = pmid_pkg::PROD1_W'(cfg.inv01) * pmid_pkg::PROD1_W'(dy_r);
    p10_nxt = pmid_pkg::PROD1_W'(cfg.inv10) * pmid_pkg::PROD1_W'(dx_r);
    p11_nxt = pmid_pkg::PROD1_W'(cfg.inv11) * pmid_pkg::PROD1_W'(dy_r);
  end

  // Stage 3: row sums, drop 16 bits to Q.28, then wrap
  always_comb begin
    acc0 = pmid_pkg::ACC1_W'(p00_r) + pmid_pkg::ACC1_W'(p01_r);
    acc1 = pmid_pkg::ACC1_W'(p10_r) + pmid_pkg::ACC1_W'(p11_r);
    frac_nxt.frac_x = wrap_frac(acc0[pmid_pkg::ACC1_W-1:pmid_pkg::Q_POS], cfg.wrap[0]);
    if (pmid_pkg::USE_Y) begin
      frac_nxt.frac_y = wrap_frac(acc1[pmid_pkg::ACC1_W-1:pmid_pkg::Q_POS], cfg.wrap[1]);
    end else begin
      frac_nxt.frac_y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
    if (rdy[1]) begin
      p00_r <= p00_nxt;
      p01_r <= p01_nxt;
      p10_r <= p10_nxt;
      p11_r <= p11_nxt;
    end
    if (rdy[2]) begin
      frac_r <= frac_nxt;
    end
  end

  assign in_stall   = !rdy[0];
  assign frac_valid = v_r[NST-1];
  assign frac_word  = frac_r;

endmodule

// ===== rtl/pmid_disp.sv =====
// Back half of the pipeline: box matrix products, saturation, squared length.
// Six register stages, the last one is the output register; depends on pmid_pkg.
`timescale 1ns / 1ps

module pmid_disp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pmid_pkg::cfg_t       cfg,
  input  logic                 frac_valid,
  output logic                 frac_stall,
  input  pmid_pkg::frac_t      frac_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pmid_pkg::out_word_t  out_word
);

  localparam int NST = 6;
  localparam logic signed [pmid_pkg::DISP_W-1:0] SAT_HI =
    pmid_pkg::DISP_W'(32'sh7FFF_FFFF);
  localparam logic signed [pmid_pkg::DISP_W-1:0] SAT_LO = ~SAT_HI;

  logic [NST-1:0] v_r, v_nxt, rdy;

  logic signed [pmid_pkg::COORD_W-1:0] fwd [2][2];
  logic signed [pmid_pkg::FRAC_W-1:0]  frac [2];

  logic signed [pmid_pkg::PPH_W-1:0]   pph_r [2][2];
  logic signed [pmid_pkg::PPH_W-1:0]   pph_nxt [2][2];
  logic signed [pmid_pkg::PPL_W-1:0]   ppl_r [2][2];
  logic signed [pmid_pkg::PPL_W-1:0]   ppl_nxt [2][2];
  logic signed [pmid_pkg::TERM_W-1:0]  term_r [2][2];
  logic signed [pmid_pkg::TERM_W-1:0]  term_nxt [2][2];
  logic signed [pmid_pkg::ACC2_W-1:0]  acc [2];
  logic signed [pmid_pkg::DISP_W-1:0]  full_r [2];
  logic signed [pmid_pkg::DISP_W-1:0]  full_nxt [2];
  logic        [pmid_pkg::DISP_W-1:0]  mag_full [2];
  logic        [pmid_pkg::COORD_W-1:0] mag_r [2];
  logic        [pmid_pkg::COORD_W-1:0] mag_nxt [2];
  logic signed [pmid_pkg::COORD_W-1:0] sat7_r [2];
  logic signed [pmid_pkg::COORD_W-1:0] sat7_nxt [2];
  logic        [1:0]                   big7_r, big7_nxt;
  logic        [pmid_pkg::DIST_W-1:0]  sq_r [2];
  logic        [pmid_pkg::DIST_W-1:0]  sq_nxt [2];
  logic signed [pmid_pkg::COORD_W-1:0] sat8_r [2];
  logic                                big8_r;
  logic        [pmid_pkg::DIST_W:0]    dist_sum;
  pmid_pkg::out_word_t                 out_r, out_nxt;

  // Stage ready chain: a stage takes a word when empty or when it drains
  always_comb begin
    rdy[NST-1] = !v_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    for (int k = 0; k < NST; k++) begin
      if (!rdy[k]) begin
        v_nxt[k] = v_r[k];
      end else if (k == 0) begin
        v_nxt[k] = frac_valid;
      end else begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Box matrix as [output axis][fraction axis]
  always_comb begin
    fwd[0][0] = cfg.fwd00;
    fwd[0][1] = cfg.fwd01;
    fwd[1][0] = cfg.fwd10;
    fwd[1][1] = cfg.fwd11;
    frac[0]   = frac_word.frac_x;
    frac[1]   = frac_word.frac_y;
  end

  // Stage 1: partial products on the high and low slices of each fraction
  always_comb begin
    for (int d = 0; d < 2; d++) begin
      for (int m = 0; m < 2; m++) begin
        pph_nxt[d][m] = pmid_pkg::PPH_W'(fwd[d][m]) *
                        pmid_pkg::PPH_W'($signed(frac[m][pmid_pkg::FRAC_W-1:pmid_pkg::LO_W]));
        ppl_nxt[d][m] = pmid_pkg::PPL_W'(fwd[d][m]) *
                        pmid_pkg::PPL_W'($signed({1'b0, frac[m][pmid_pkg::LO_W-1:0]}));
      end
    end
  end

  // Stage 2: join the slices into full products
  always_comb begin
    for (int d = 0; d < 2; d++) begin
      for (int m = 0; m < 2; m++) begin
        term_nxt[d][m] = (pmid_pkg::TERM_W'(pph_r[d][m]) <<< pmid_pkg::LO_W) +
                         pmid_pkg::TERM_W'(ppl_r[d][m]);
      end
    end
  end

  // Stage 3: row sums back to Q16.16 (floor); drop the y axis in one dimension
  always_comb begin
    for (int d = 0; d < 2; d++) begin
      acc[d] = pmid_pkg::ACC2_W'(term_r[d][0]) + pmid_pkg::ACC2_W'(term_r[d][1]);
      if (pmid_pkg::USE_Y || d == 0) begin
        full_nxt[d] = acc[d][pmid_pkg::ACC2_W-1:pmid_pkg::Q_INV];
      end else begin
        full_nxt[d] = '0;
      end
    end
  end

  // Stage 4: saturate the field, take the magnitude, flag magnitudes past 32 bits
  always_comb begin
    for (int d = 0; d < 2; d++) begin
      if (full_r[d] > SAT_HI) begin
        sat7_nxt[d] = 32'sh7FFF_FFFF;
      end else if (full_r[d] < SAT_LO) begin
        sat7_nxt[d] = 32'sh8000_0000;
      end else begin
        sat7_nxt[d] = full_r[d][pmid_pkg::COORD_W-1:0];
      end
      mag_full[d] = full_r[d][pmid_pkg::DISP_W-1] ? -full_r[d] : full_r[d];
      mag_nxt[d]  = mag_full[d][pmid_pkg::COORD_W-1:0];
      big7_nxt[d] = |mag_full[d][pmid_pkg::DISP_W-1:pmid_pkg::COORD_W];
    end
  end

  // Stage 5: square each magnitude
  always_comb begin
    for (int d = 0; d < 2; d++) begin
      sq_nxt[d] = pmid_pkg::DIST_W'(mag_r[d]) * pmid_pkg::DIST_W'(mag_r[d]);
    end
  end

  // Stage 6: add the squares, saturate on any overflow
  always_comb begin
    dist_sum = (pmid_pkg::DIST_W + 1)'(sq_r[0]) + (pmid_pkg::DIST_W + 1)'(sq_r[1]);
    out_nxt.disp_x = sat8_r[0];
    out_nxt.disp_y = sat8_r[1];
    if (big8_r || dist_sum[pmid_pkg::DIST_W]) begin
      out_nxt.dist_sq = '1;
    end else begin
      out_nxt.dist_sq = dist_sum[pmid_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pph_r <= pph_nxt;
      ppl_r <= ppl_nxt;
    end
    if (rdy[1]) begin
      term_r <= term_nxt;
    end
    if (rdy[2]) begin
      full_r <= full_nxt;
    end
    if (rdy[3]) begin
      sat7_r <= sat7_nxt;
      mag_r  <= mag_nxt;
      big7_r <= big7_nxt;
    end
    if (rdy[4]) begin
      sq_r   <= sq_nxt;
      sat8_r <= sat7_r;
      big8_r <= |big7_r;
    end
    if (rdy[5]) begin
      out_r <= out_nxt;
    end
  end

  assign frac_stall = !rdy[0];
  assign out_valid  = v_r[NST-1];
  assign out_word   = out_r;

  // Back-pressure upstream only when every stage holds a word
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    frac_stall |-> (&v_r))
    else $error("upstream stalled while a stage is empty");

  // A word taken in shows up in the first stage
  a_take_in: assert property (@(posedge clk) disable iff (!rst_n)
    frac_valid && !frac_stall |=> v_r[0])
    else $error("accepted word lost at stage one");

  // A blocked middle stage keeps its word
  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] && !rdy[4] |=> v_r[3] && $stable(mag_r[0]) && $stable(big7_r))
    else $error("stalled stage dropped or changed its word");

  // An oversized magnitude always ends as a saturated length
  a_big_sat: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4] && big8_r && rdy[5] |=> out_r.dist_sq == '1)
    else $error("overflowing magnitude not saturated");

endmodule

// ===== rtl/periodic_min_image_distance.sv =====
// Minimum-image displacement and squared distance in a periodic 2-D box.
// Nine stage registers lie between the accepting edge and out_valid.
// Throughput: one word per cycle; every stage advances each cycle unless out_stall holds
//   the pipeline, with the box products split into 32 by 25 bit partial products.
// Reset (rst_n low, synchronous) empties the pipeline and loads identity matrices
//   with wrapping off.
`timescale 1ns / 1ps

module periodic_min_image_distance (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  pmid_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output pmid_pkg::out_word_t              out_data,
  input  logic                             cfg_we,
  input  logic [pmid_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [pmid_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  pmid_pkg::cfg_t  cfg;
  pmid_pkg::frac_t frac_word;
  logic            frac_valid;
  logic            frac_stall;

  // Configuration registers
  pmid_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Difference and box fractions
  pmid_frac u_frac (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_data),
    .frac_valid (frac_valid),
    .frac_stall (frac_stall),
    .frac_word  (frac_word)
  );

  // Displacement and squared length
  pmid_disp u_disp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .frac_valid (frac_valid),
    .frac_stall (frac_stall),
    .frac_word  (frac_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_data)
  );

endmodule
